@@ sv/tbsc_pkg.sv @@
// shared types and constants of the triple buffer swap controller
package tbsc_pkg;

  localparam int BUF_CNT = 3;
  localparam int IDX_W = 2;
  localparam int CNT_W = $clog2(BUF_CNT + 1);
  localparam int SUM_W = $clog2(2 * BUF_CNT);
  localparam int PC_W = 8;
  localparam int SKIP_W = 8;
  localparam int BLANK_W = 9;
  localparam int FREE_W = 2;

  localparam logic [PC_W-1:0] PC_MAX = 8'hFF;
  localparam logic [PC_W-1:0] PC_INIT = PC_MAX - 8'd1;
  localparam logic [FREE_W-1:0] FREE_MAX = 2'd3;
  localparam logic [IDX_W-1:0] INIT_ZERO_IDX = IDX_W'(1);
  localparam logic [IDX_W-1:0] INIT_SHOWN = IDX_W'(BUF_CNT - 1);

  typedef enum logic [1:0] {
    KIND_VBLANK      = 2'd0,
    KIND_RENDER_DONE = 2'd1,
    KIND_ACQUIRE     = 2'd2,
    KIND_RECOVER     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] done_index;
  } event_t;

  typedef struct packed {
    logic              shown_valid;
    logic [IDX_W-1:0]  shown_index;
    logic              granted;
    logic [IDX_W-1:0]  grant_index;
    logic              acquire_error;
    logic [FREE_W-1:0] free_buffers;
    logic              frame_blocked;
  } result_t;

  // ring position wrap; the sum stays below twice the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] w;
    w = (s >= SUM_W'(BUF_CNT)) ? s - SUM_W'(BUF_CNT) : s;
    return w[IDX_W-1:0];
  endfunction

endpackage

@@ sv/tbsc_in_stage.sv @@
// input register of the event channel
module tbsc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_kind,
  input  logic [1:0]      in_done_index,
  input  logic            advance,
  output logic            stage_valid,
  output tbsc_pkg::event_t stage_ev
);
  import tbsc_pkg::*;

  logic   stage_valid_r, stage_valid_nxt;
  event_t stage_ev_r;
  logic   accept;

  // stall only when the held transaction cannot move on
  assign in_stall = stage_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_ev_r.kind       <= kind_t'(in_kind);
      stage_ev_r.done_index <= in_done_index;
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage_ev    = stage_ev_r;
endmodule

@@ sv/tbsc_core.sv @@
// buffer state and the per-event update logic
module tbsc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              fire,
  input  tbsc_pkg::event_t  ev,
  output tbsc_pkg::result_t res
);
  import tbsc_pkg::*;

  logic [PC_W-1:0]    pc_r [BUF_CNT];
  logic [PC_W-1:0]    pc_nxt [BUF_CNT];
  logic [IDX_W-1:0]   rq_r [BUF_CNT];
  logic [IDX_W-1:0]   rq_nxt [BUF_CNT];
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   shown_r, shown_nxt;
  logic [FREE_W-1:0]  free_r, free_nxt;
  logic               blocked_r, blocked_nxt;
  logic [BLANK_W-1:0] blank_r, blank_nxt;
  logic [SKIP_W-1:0]  skip_r;

  logic [BLANK_W-1:0] blank_inc;
  logic [IDX_W-1:0]   pop_idx;
  logic [IDX_W-1:0]   push_pos;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic               shown_valid, granted, acq_err;
  logic [IDX_W-1:0]   grant_idx;

  // frame skip register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
    end else if (cfg_we) begin
      skip_r <= cfg_wdata;
    end
  end

  assign blank_inc = blank_r + BLANK_W'(1);
  assign pop_idx   = rq_r[head_r];
  assign push_pos  = wrap_idx(SUM_W'(head_r) + SUM_W'(count_r));

  // lowest buffer with a zero pass counter
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = BUF_CNT - 1; i >= 0; i--) begin
      if (pc_r[i] == '0) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // event update
  always_comb begin
    pc_nxt      = pc_r;
    rq_nxt      = rq_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    shown_nxt   = shown_r;
    free_nxt    = free_r;
    blocked_nxt = blocked_r;
    blank_nxt   = blank_r;
    shown_valid = 1'b0;
    granted     = 1'b0;
    grant_idx   = '0;
    acq_err     = 1'b0;
    unique case (ev.kind)
      KIND_VBLANK: begin
        blank_nxt = blank_inc;
        if (blank_inc > BLANK_W'(skip_r)) begin
          blank_nxt = '0;
          if (count_r != '0) begin
            head_nxt          = wrap_idx(SUM_W'(head_r) + SUM_W'(1));
            count_nxt         = count_r - CNT_W'(1);
            pc_nxt[pop_idx]   = pc_r[pop_idx] + PC_W'(1);
            // released buffer clears after the bump, so it wins on a repeat
            pc_nxt[shown_r]   = '0;
            if (free_r != FREE_MAX) begin
              free_nxt = free_r + FREE_W'(1);
            end
            shown_nxt   = pop_idx;
            shown_valid = 1'b1;
          end
        end
      end
      KIND_RENDER_DONE: begin
        if (ev.done_index < IDX_W'(BUF_CNT)) begin
          pc_nxt[ev.done_index] = pc_r[ev.done_index] + PC_W'(1);
          if (count_r < CNT_W'(BUF_CNT)) begin
            rq_nxt[push_pos] = ev.done_index;
            count_nxt        = count_r + CNT_W'(1);
          end
          blocked_nxt = 1'b0;
        end
      end
      KIND_ACQUIRE: begin
        if (free_r != '0 && !blocked_r) begin
          if (found) begin
            granted     = 1'b1;
            grant_idx   = found_idx;
            free_nxt    = free_r - FREE_W'(1);
            blocked_nxt = 1'b1;
          end else begin
            acq_err = 1'b1;
          end
        end
      end
      KIND_RECOVER: begin
        free_nxt    = FREE_W'(1);
        blocked_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUF_CNT; i++) begin
        pc_r[i] <= (IDX_W'(i) == INIT_ZERO_IDX) ? '0 : PC_INIT;
        rq_r[i] <= '0;
      end
      head_r    <= '0;
      count_r   <= CNT_W'(1);
      shown_r   <= INIT_SHOWN;
      free_r    <= FREE_W'(1);
      blocked_r <= 1'b0;
      blank_r   <= '0;
    end else if (fire) begin
      pc_r      <= pc_nxt;
      rq_r      <= rq_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      shown_r   <= shown_nxt;
      free_r    <= free_nxt;
      blocked_r <= blocked_nxt;
      blank_r   <= blank_nxt;
    end
  end

  assign res.shown_valid   = shown_valid;
  assign res.shown_index   = shown_nxt;
  assign res.granted       = granted;
  assign res.grant_index   = grant_idx;
  assign res.acquire_error = acq_err;
  assign res.free_buffers  = free_nxt;
  assign res.frame_blocked = blocked_nxt;
endmodule

@@ sv/tbsc_out_reg.sv @@
// result register of the output channel
module tbsc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  tbsc_pkg::result_t res,
  input  logic              out_stall,
  output logic              advance,
  output logic              out_valid,
  output tbsc_pkg::result_t out_res
);
  import tbsc_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // register may load when empty or when its transaction is taken
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
endmodule

@@ sv/triple_buffer_swap_controller.sv @@
// an event passes the input register, then the result register; out_stall can hold it between
// throughput: one event per cycle unless stalled; state update is one pass through tbsc_core
// a held result does not block a new input while the input register is free
// reset: synchronous active low; pass counters 254 except buffer 1 at 0, buffer 2 shown,
// ready queue holds buffer 0, one free buffer, frame skip 0; no clearing pass
module triple_buffer_swap_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [1:0] in_done_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_shown_valid,
  output logic [1:0] out_shown_index,
  output logic       out_granted,
  output logic [1:0] out_grant_index,
  output logic       out_acquire_error,
  output logic [1:0] out_free_buffers,
  output logic       out_frame_blocked
);
  import tbsc_pkg::*;

  logic    advance;
  logic    stage_valid;
  logic    fire;
  event_t  stage_ev;
  result_t res;
  result_t out_res;

  tbsc_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_done_index (in_done_index),
    .advance       (advance),
    .stage_valid   (stage_valid),
    .stage_ev      (stage_ev)
  );

  assign fire = stage_valid && advance;

  tbsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .ev        (stage_ev),
    .res       (res)
  );

  tbsc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_shown_valid   = out_res.shown_valid;
  assign out_shown_index   = out_res.shown_index;
  assign out_granted       = out_res.granted;
  assign out_grant_index   = out_res.grant_index;
  assign out_acquire_error = out_res.acquire_error;
  assign out_free_buffers  = out_res.free_buffers;
  assign out_frame_blocked = out_res.frame_blocked;
endmodule

@@ sv/tbsc_checker.sv @@
// port-level checks of the swap controller and their bind
module tbsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_shown_valid,
  input logic [1:0] out_shown_index,
  input logic       out_granted,
  input logic [1:0] out_grant_index,
  input logic       out_acquire_error,
  input logic [1:0] out_free_buffers,
  input logic       out_frame_blocked
);
  import tbsc_pkg::*;

  // a grant always sets the block flag
  a_grant_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_frame_blocked)
    else $error("grant without block flag");

  // one transaction never both grants and errors, nor grants and switches display
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && (out_acquire_error || out_shown_valid)))
    else $error("conflicting result flags");

  // granted and shown buffers stay in range
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shown_index < IDX_W'(BUF_CNT)
              && (!out_granted || out_grant_index < IDX_W'(BUF_CNT)))
    else $error("buffer index out of range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shown_index)
                            && $stable(out_free_buffers) && $stable(out_granted))
    else $error("stalled result changed");
endmodule

bind triple_buffer_swap_controller tbsc_checker u_tbsc_checker (.*);
